// ----- sv/bccr_pkg.sv -----
package bccr_pkg;

  localparam int unsigned FileW  = 10;
  localparam int unsigned BlockW = 32;

  localparam logic [1:0] REQ_ACCESS = 2'd0;
  localparam logic [1:0] REQ_DIRTY  = 2'd1;
  localparam logic [1:0] REQ_FLUSH  = 2'd2;

  localparam logic [2:0] ST_HIT    = 3'd0;
  localparam logic [2:0] ST_MISS   = 3'd1;
  localparam logic [2:0] ST_MARKED = 3'd2;
  localparam logic [2:0] ST_ABSENT = 3'd3;
  localparam logic [2:0] ST_FLUSH  = 3'd4;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [FileW-1:0]  file_id;
    logic [BlockW-1:0] block_number;
  } req_t;

  typedef struct packed {
    logic [2:0]        status;
    logic              fetch_needed;
    logic              writeback_valid;
    logic [FileW-1:0]  writeback_file;
    logic [BlockW-1:0] writeback_block;
    logic              last;
  } rsp_t;

endpackage

// ----- sv/bccr_match.sv -----
module bccr_match
  import bccr_pkg::*;
(
  input  logic [FileW-1:0]  ent_file_i,
  input  logic [BlockW-1:0] ent_block_i,
  input  logic [FileW-1:0]  key_file_i,
  input  logic [BlockW-1:0] key_block_i,
  output logic              file_eq_o,
  output logic              key_eq_o
);

  // The single shared comparator; the sequencer presents one entry per cycle.
  assign file_eq_o = (ent_file_i == key_file_i);
  assign key_eq_o  = file_eq_o && (ent_block_i == key_block_i);

endmodule

// ----- sv/block_cache_clock_replacement.sv -----
// Tag store of a block cache with clock (second chance) replacement.
// Requests arrive on the req channel (req_valid_i, req_stall_o, req_i) and
// results leave on the rsp channel (rsp_valid_o, rsp_stall_i, rsp_o). A
// transfer happens at an edge where valid is high and stall is low.
// One request is worked at a time by a sequencer around one shared key
// comparator. Access and mark dirty scan the list one entry per cycle and
// then decide. A miss on a full list then runs the clock sweep one entry
// per cycle (at most one full pass of clearing and one hit) and shifts
// later entries down one per cycle. Flush visits every entry and removes
// matches with a shift each; it emits one transfer per removed entry plus
// a closing transfer with last. Each result sits in an output register;
// while the receiver stalls the result holds and the sequencer waits
// before the next result. A new request is taken only after the final
// result of the previous one has been transferred. Reset empties the list,
// parks the hand at zero and sets cache_capacity to 16. The capacity
// register is at APB address 0 and should be written only while the
// block is idle.
module block_cache_clock_replacement
  import bccr_pkg::*;
#(
  parameter int unsigned MaxEntries = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_valid_i,
  output logic        req_stall_o,
  input  req_t        req_i,
  output logic        rsp_valid_o,
  input  logic        rsp_stall_i,
  output rsp_t        rsp_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned IdxW = (MaxEntries > 1) ? $clog2(MaxEntries) : 1;
  localparam int unsigned CntW = $clog2(MaxEntries + 1);
  localparam int unsigned PasW = $clog2(2 * MaxEntries + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_SWEEP = 3'd2;
  localparam logic [2:0] S_SHIFT = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;
  localparam logic [2:0] S_FLUSH = 3'd5;
  localparam logic [2:0] S_FSHF  = 3'd6;

  logic [FileW-1:0]      efile_q  [MaxEntries];
  logic [BlockW-1:0]     eblock_q [MaxEntries];
  logic [MaxEntries-1:0] ref_q, dirty_q;
  logic [CntW-1:0]       count_q;
  logic [IdxW-1:0]       hand_q;
  logic [4:0]            cap_q;
  logic [2:0]            state_q;
  logic [CntW-1:0]       idx_q;
  logic [PasW-1:0]       steps_q;
  req_t                  req_q;
  rsp_t                  rsp_q;
  logic                  out_q;
  logic                  fshift_q;
  logic                  flush_q;

  logic            file_eq, key_eq;
  logic [IdxW-1:0] ix;
  logic [CntW-1:0] eff_cap;
  logic [CntW-1:0] idx_nx;

  assign ix     = idx_q[IdxW-1:0];
  assign idx_nx = idx_q + 1'b1;

  bccr_match u_match (
    .ent_file_i (efile_q[ix]),
    .ent_block_i(eblock_q[ix]),
    .key_file_i (req_q.file_id),
    .key_block_i(req_q.block_number),
    .file_eq_o  (file_eq),
    .key_eq_o   (key_eq)
  );

  always_comb begin
    if (cap_q == 5'd0) eff_cap = CntW'(1);
    else if ({27'd0, cap_q} > 32'(MaxEntries)) eff_cap = CntW'(MaxEntries);
    else eff_cap = CntW'(cap_q);
  end

  assign pready      = 1'b1;
  assign prdata      = (paddr == 2'd0) ? {27'd0, cap_q} : 32'd0;
  assign req_stall_o = (state_q != S_IDLE);
  assign rsp_valid_o = out_q;
  assign rsp_o       = rsp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= 5'd16;
    end else if (psel && penable && pwrite && paddr == 2'd0) begin
      cap_q <= pwdata[4:0];
    end
  end

  // Key storage: payload only, written at one index per cycle.
  always_ff @(posedge clk_i) begin
    if ((state_q == S_SHIFT || state_q == S_FSHF) && idx_nx < count_q) begin
      efile_q[ix]  <= efile_q[IdxW'(idx_nx)];
      eblock_q[ix] <= eblock_q[IdxW'(idx_nx)];
    end else if (state_q == S_SHIFT && !(idx_nx < count_q)
                 && count_q <= CntW'(MaxEntries)) begin
      // append happens in the cycle after shifting
    end
    if (state_q == S_OUT && fshift_q) begin
      efile_q[IdxW'(count_q)]  <= req_q.file_id;
      eblock_q[IdxW'(count_q)] <= req_q.block_number;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ref_q    <= '0;
      dirty_q  <= '0;
      count_q  <= '0;
      hand_q   <= '0;
      idx_q    <= '0;
      steps_q  <= '0;
      out_q    <= 1'b0;
      fshift_q <= 1'b0;
      flush_q  <= 1'b0;
      req_q    <= '0;
      rsp_q    <= '0;
    end else begin
      if (out_q && !rsp_stall_i) out_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (req_valid_i) begin
            req_q   <= req_i;
            idx_q   <= '0;
            rsp_q   <= '0;
            flush_q <= 1'b0;
            if (req_i.req_type == REQ_FLUSH) state_q <= S_FLUSH;
            else if (req_i.req_type == REQ_ACCESS || req_i.req_type == REQ_DIRTY)
              state_q <= S_SCAN;
            else begin
              rsp_q.status <= ST_ABSENT;
              rsp_q.last   <= 1'b1;
              out_q        <= 1'b1;
              state_q      <= S_OUT;
            end
          end
        end
        S_SCAN: begin
          if (idx_q < count_q && key_eq) begin
            rsp_q.last <= 1'b1;
            out_q      <= 1'b1;
            state_q    <= S_OUT;
            if (req_q.req_type == REQ_ACCESS) begin
              ref_q[ix]    <= 1'b1;
              rsp_q.status <= ST_HIT;
            end else begin
              dirty_q[ix]  <= 1'b1;
              rsp_q.status <= ST_MARKED;
            end
          end else if (idx_q < count_q) begin
            idx_q <= idx_nx;
          end else if (req_q.req_type == REQ_DIRTY) begin
            rsp_q.status <= ST_ABSENT;
            rsp_q.last   <= 1'b1;
            out_q        <= 1'b1;
            state_q      <= S_OUT;
          end else begin
            rsp_q.status       <= ST_MISS;
            rsp_q.fetch_needed <= 1'b1;
            rsp_q.last         <= 1'b1;
            if (count_q >= eff_cap && count_q != '0) begin
              // hand modulo count: hand < MaxEntries, count <= MaxEntries,
              // but count may have shrunk, so at most one wrap is not enough
              // in general; walk it down by reduction in S_SWEEP entry.
              idx_q   <= CntW'(hand_q);
              steps_q <= '0;
              state_q <= S_SWEEP;
            end else begin
              fshift_q <= count_q < CntW'(MaxEntries);
              out_q    <= 1'b1;
              state_q  <= S_OUT;
            end
          end
        end
        S_SWEEP: begin
          if (idx_q >= count_q) begin
            idx_q <= idx_q - count_q;      // one subtract per cycle: modulo
          end else if (!ref_q[ix] || steps_q >= {count_q, 1'b0}) begin
            hand_q <= ix;
            rsp_q.writeback_valid <= dirty_q[ix];
            if (dirty_q[ix]) begin
              rsp_q.writeback_file  <= efile_q[ix];
              rsp_q.writeback_block <= eblock_q[ix];
            end
            state_q <= S_SHIFT;
          end else begin
            ref_q[ix] <= 1'b0;
            steps_q   <= steps_q + 1'b1;
            idx_q     <= (idx_nx == count_q) ? '0 : idx_nx;
            hand_q    <= (idx_nx == count_q) ? '0 : IdxW'(idx_nx);
          end
        end
        S_SHIFT, S_FSHF: begin
          if (idx_nx < count_q) begin
            ref_q[ix]   <= ref_q[IdxW'(idx_nx)];
            dirty_q[ix] <= dirty_q[IdxW'(idx_nx)];
            idx_q       <= idx_nx;
          end else begin
            count_q <= count_q - 1'b1;
            if (state_q == S_SHIFT) begin
              fshift_q <= 1'b1;
              out_q    <= 1'b1;
              state_q  <= S_OUT;
            end else begin
              idx_q   <= '0;
              state_q <= S_OUT;
              flush_q <= 1'b1;
            end
          end
        end
        S_FLUSH: begin
          if (idx_q < count_q && file_eq) begin
            rsp_q.status          <= ST_FLUSH;
            rsp_q.writeback_valid <= dirty_q[ix];
            rsp_q.writeback_file  <= dirty_q[ix] ? efile_q[ix] : '0;
            rsp_q.writeback_block <= dirty_q[ix] ? eblock_q[ix] : '0;
            rsp_q.last            <= 1'b0;
            out_q                 <= 1'b1;
            if (ix < hand_q) hand_q <= hand_q - 1'b1;
            else if (CntW'(hand_q) >= count_q - 1'b1) hand_q <= '0;
            steps_q <= PasW'(idx_q);
            state_q <= S_FSHF;
          end else if (idx_q < count_q) begin
            idx_q <= idx_nx;
          end else begin
            rsp_q        <= '0;
            rsp_q.status <= ST_FLUSH;
            rsp_q.last   <= 1'b1;
            out_q        <= 1'b1;
            state_q      <= S_OUT;
          end
        end
        S_OUT: begin
          if (fshift_q) begin
            ref_q[IdxW'(count_q)]   <= 1'b1;
            dirty_q[IdxW'(count_q)] <= 1'b0;
            count_q                 <= count_q + 1'b1;
            fshift_q                <= 1'b0;
          end else if (flush_q) begin
            // shift done; wait for the step result, then resume the scan
            if (!out_q || !rsp_stall_i) begin
              flush_q <= 1'b0;
              idx_q   <= CntW'(steps_q);
              state_q <= S_FLUSH;
            end
          end else if (!out_q || !rsp_stall_i) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- bench/block_cache_clock_replacement_test.sv -----
`timescale 1ns / 100ps

// Self-checking bench for the clock replacement tag store.
// A queue of pending requests is filled by the stimulus process. A clocked
// driver presents them on the request channel with random idle bursts. A
// clocked monitor takes each result transfer and compares it against the
// oldest predicted result. Predictions come from a local model of the list,
// the reference bits, the dirty bits and the clock hand, updated whenever
// a request transfer is seen.
module block_cache_clock_replacement_test;
  import bccr_pkg::*;

  localparam int unsigned Slots = 16;
  localparam int unsigned CycleLimit = 1000000;

  logic        clk_i;
  logic        rst_ni;
  logic        req_valid_i;
  logic        req_stall_o;
  req_t        req_i;
  logic        rsp_valid_o;
  logic        rsp_stall_i;
  rsp_t        rsp_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [1:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  block_cache_clock_replacement DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid_i),
    .req_stall_o (req_stall_o),
    .req_i       (req_i),
    .rsp_valid_o (rsp_valid_o),
    .rsp_stall_i (rsp_stall_i),
    .rsp_o       (rsp_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // Local copy of the tag store.
  logic [FileW-1:0]  tag_file [Slots];
  logic [BlockW-1:0] tag_block [Slots];
  logic              tag_ref [Slots];
  logic              tag_dirty [Slots];
  int unsigned       tag_count;
  int unsigned       hand;
  logic [4:0]        capacity_reg;

  req_t pending_reqs[$];
  rsp_t expected_rsps[$];
  int   errors = 0;
  int   cycles = 0;
  bit   idle_allowed;
  int   send_gap;
  int   stall_gap;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("%0t: timeout with %0d results outstanding", $time, expected_rsps.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic int find_entry(logic [FileW-1:0] f, logic [BlockW-1:0] b);
    for (int i = 0; i < int'(tag_count); i++)
      if (tag_file[i] == f && tag_block[i] == b) return i;
    return -1;
  endfunction

  function automatic void drop_entry(int unsigned idx);
    for (int unsigned i = idx; i + 1 < tag_count; i++) begin
      tag_file[i]  = tag_file[i+1];
      tag_block[i] = tag_block[i+1];
      tag_ref[i]   = tag_ref[i+1];
      tag_dirty[i] = tag_dirty[i+1];
    end
    if (tag_count > 0) tag_count--;
  endfunction

  function automatic rsp_t make_rsp(logic [2:0] st, logic fetch, logic wbv,
                                    logic [FileW-1:0] f, logic [BlockW-1:0] b,
                                    logic fin);
    rsp_t r;
    r.status          = st;
    r.fetch_needed    = fetch;
    r.writeback_valid = wbv;
    r.writeback_file  = wbv ? f : '0;
    r.writeback_block = wbv ? b : '0;
    r.last            = fin;
    return r;
  endfunction

  // Appends one predicted result at the tail of the expected queue.
  function automatic void expect_rsp(rsp_t r);
    expected_rsps.insert(expected_rsps.size(), r);
  endfunction

  // Advance the local store by one request and queue the results it causes.
  function automatic void predict_request(req_t rq);
    int               hit;
    int unsigned      cap;
    int unsigned      i;
    logic             wbv;
    logic [FileW-1:0] wf;
    logic [BlockW-1:0] wb;
    wbv = 1'b0;
    wf  = '0;
    wb  = '0;
    cap = (capacity_reg == 0) ? 1 : (capacity_reg > Slots) ? Slots : capacity_reg;
    hit = find_entry(rq.file_id, rq.block_number);
    case (rq.req_type)
      REQ_ACCESS: begin
        if (hit >= 0) begin
          tag_ref[hit] = 1'b1;
          expect_rsp(make_rsp(ST_HIT, 0, 0, '0, '0, 1));
        end else begin
          if (tag_count >= cap && tag_count > 0) begin
            // Second chance sweep: two passes always find a victim.
            hand = hand % tag_count;
            for (int k = 0; k < 2 * int'(tag_count); k++) begin
              if (!tag_ref[hand]) begin
                wbv = tag_dirty[hand];
                wf  = tag_file[hand];
                wb  = tag_block[hand];
                drop_entry(hand);
                break;
              end
              tag_ref[hand] = 1'b0;
              hand = (hand + 1) % tag_count;
            end
          end
          if (tag_count < Slots) begin
            tag_file[tag_count]  = rq.file_id;
            tag_block[tag_count] = rq.block_number;
            tag_ref[tag_count]   = 1'b1;
            tag_dirty[tag_count] = 1'b0;
            tag_count++;
          end
          expect_rsp(make_rsp(ST_MISS, 1, wbv, wf, wb, 1));
        end
      end
      REQ_DIRTY: begin
        if (hit >= 0) begin
          tag_dirty[hit] = 1'b1;
          expect_rsp(make_rsp(ST_MARKED, 0, 0, '0, '0, 1));
        end else begin
          expect_rsp(make_rsp(ST_ABSENT, 0, 0, '0, '0, 1));
        end
      end
      REQ_FLUSH: begin
        i = 0;
        while (i < tag_count) begin
          if (tag_file[i] == rq.file_id) begin
            expect_rsp(make_rsp(ST_FLUSH, 0, tag_dirty[i], tag_file[i],
                                tag_block[i], 0));
            drop_entry(i);
            if (i < hand) hand--;
            else if (hand >= tag_count) hand = 0;
          end else begin
            i++;
          end
        end
        expect_rsp(make_rsp(ST_FLUSH, 0, 0, '0, '0, 1));
      end
      default: expect_rsp(make_rsp(ST_ABSENT, 0, 0, '0, '0, 1));
    endcase
  endfunction

  // Request driver with random idle bursts.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_i <= 1'b0;
      req_i       <= '0;
      send_gap    <= 0;
    end else if (!(req_valid_i && req_stall_o)) begin
      if (req_valid_i && !req_stall_o) predict_request(req_i);
      if (send_gap > 0) begin
        send_gap    <= send_gap - 1;
        req_valid_i <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        req_i       <= pending_reqs.pop_front();
        req_valid_i <= 1'b1;
        if (idle_allowed && $urandom_range(0, 5) == 0) send_gap <= $urandom_range(1, 16);
      end else begin
        req_valid_i <= 1'b0;
      end
    end
  end

  // Result monitor; stalls come in random bursts as well.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_stall_i <= 1'b0;
      stall_gap   <= 0;
    end else begin
      if (rsp_valid_o && !rsp_stall_i) begin
        if (expected_rsps.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %p", $time, rsp_o);
          errors <= errors + 1;
        end else begin
          rsp_t exp_r;
          exp_r = expected_rsps.pop_front();
          if (rsp_o !== exp_r) begin
            $display("%0t: result mismatch, expected %p, actual %p", $time, exp_r, rsp_o);
            errors <= errors + 1;
          end
        end
      end
      if (stall_gap > 0) begin
        stall_gap   <= stall_gap - 1;
        rsp_stall_i <= 1'b1;
      end else if (idle_allowed && $urandom_range(0, 7) == 0) begin
        stall_gap   <= $urandom_range(0, 15);
        rsp_stall_i <= 1'b1;
      end else begin
        rsp_stall_i <= 1'b0;
      end
    end
  end

  // Waits until every queued request has gone and every result has come.
  task automatic drain();
    while (pending_reqs.size() > 0 || req_valid_i || expected_rsps.size() > 0)
      @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic write_capacity(logic [4:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= '0;
    pwdata  <= {27'd0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    capacity_reg = value;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic queue_req(logic [1:0] kind, logic [FileW-1:0] f, logic [BlockW-1:0] b);
    req_t rq;
    rq.req_type     = kind;
    rq.file_id      = f;
    rq.block_number = b;
    pending_reqs.insert(pending_reqs.size(), rq);
  endtask

  // A run of requests over a few files and a small block range so that hits,
  // evictions and flushes all happen often.
  task automatic queue_random(int n, int files);
    logic [FileW-1:0] f;
    int pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 19);
      f = (files == 0) ? FileW'($urandom) : FileW'($urandom_range(0, files - 1) * 341);
      if (pick < 11)
        queue_req(REQ_ACCESS, f, $urandom_range(0, 9) ^ (pick == 0 ? 32'hFFFF_FFF0 : 0));
      else if (pick < 16)
        queue_req(REQ_DIRTY, f, $urandom_range(0, 9));
      else if (pick < 18)
        queue_req(REQ_FLUSH, f, $urandom);
      else
        queue_req(2'($urandom_range(0, 3)), FileW'($urandom), $urandom);
    end
  endtask

  initial begin
    idle_allowed = 1'b1;
    capacity_reg = 5'd16;
    tag_count    = 0;
    hand         = 0;
    for (int i = 0; i < Slots; i++) begin
      tag_ref[i]   = 1'b0;
      tag_dirty[i] = 1'b0;
    end
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    rst_ni  = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at the reset capacity: extreme keys, every request kind,
    // the unknown kind, a full list with all reference bits set, and flush.
    queue_req(REQ_ACCESS, '1, '1);
    queue_req(REQ_ACCESS, '0, '0);
    queue_req(REQ_ACCESS, '1, '1);
    queue_req(REQ_DIRTY, '1, '1);
    queue_req(REQ_DIRTY, 10'h155, 32'hAAAA_5555);
    queue_req(2'd3, 10'h2AA, 32'h5555_AAAA);
    for (int i = 0; i < 15; i++) queue_req(REQ_ACCESS, 10'h0F0, i + 2);
    queue_req(REQ_ACCESS, 10'h30F, 32'h8000_0001);
    queue_req(REQ_FLUSH, 10'h0F0, '1);
    queue_req(REQ_FLUSH, '1, '0);
    drain();

    // Smallest capacity: every miss evicts, dirty victims write back.
    write_capacity(5'd1);
    queue_req(REQ_ACCESS, 10'd5, 32'd1);
    queue_req(REQ_DIRTY, 10'd5, 32'd1);
    queue_req(REQ_ACCESS, 10'd6, 32'd2);
    queue_random(30, 2);
    drain();

    // Capacity zero acts as one, values above the list size act as the size.
    write_capacity(5'd0);
    queue_random(20, 2);
    drain();
    write_capacity(5'd31);
    queue_random(60, 3);
    drain();

    // Mid capacity with wide keys, then the sender holds off entirely until
    // all results are back before the closing phase.
    write_capacity(5'd4);
    queue_random(60, 2);
    queue_random(10, 0);
    drain();

    write_capacity(5'd16);
    queue_random(30, 4);
    drain();
    idle_allowed = 1'b0;
    queue_random(40, 3);
    drain();

    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
